// ----- rtl/core/pga_pkg.sv -----
// pga_pkg: constants, codes and item types shared by the page allocator core
// and its testbench. No dependencies.
package pga_pkg;

   localparam int NUM_PAGES = 32;
   localparam int PAGE_KB   = 4;
   localparam int ID_BITS   = 8;

   localparam int PAGE_BITS = $clog2(NUM_PAGES);
   localparam int CNT_BITS  = $clog2(NUM_PAGES + 1);
   localparam int SIZE_BITS = 10;
   // size plus rounding term, and the rounded page count
   localparam int SUM_BITS  = $clog2((1 << SIZE_BITS) + PAGE_KB);
   localparam int NEED_BITS = (SUM_BITS > CNT_BITS) ? SUM_BITS : CNT_BITS;

   localparam int STATUS_W = 2;
   localparam int PAGES_W  = 6;
   localparam int START_W  = 5;
   localparam int FRAGS_W  = 5;

   localparam logic [1:0] OP_ADD  = 2'd0;
   localparam logic [1:0] OP_KILL = 2'd1;
   localparam logic [1:0] OP_FRAG = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RUNNING = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;

   typedef struct packed {
      logic [1:0]           op;
      logic [7:0]           program_id;
      logic [SIZE_BITS-1:0] size_kb;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGES_W-1:0]  pages;
      logic [START_W-1:0]  start_page;
      logic [FRAGS_W-1:0]  fragments;
   } rsp_item_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_FILL,
      S_FINISH
   } state_type;

endpackage

// ----- rtl/core/pga_ram.sv -----
// pga_ram: generic single-write, single-read ram with registered read data.
// Standalone, no package needed.
module pga_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/page_allocator_best_worst_fit_core.sv -----
// page_allocator_best_worst_fit_core: contiguous best/worst fit page allocator.
// Uses pga_pkg and one pga_ram instance holding the page owner table.
//
//   port group  dir  handshake        item
//   req_*       in   valid / stall    req_item_type (op, program_id, size_kb)
//   rsp_*       out  valid / stall    rsp_item_type (status, pages, start_page, fragments)
//   csr_*       in   valid / ready    fit_mode, always ready
//
// Every item with a known op walks the owner ram once, one page per cycle; a
// successful add then writes its pages in a fill step. An unused op code skips
// the walk. The single ram read port sets the walk rate. Used bits live in flops,
// so reset frees all pages at once with no clearing pass. A held result does
// not block the next item's scan; it only waits at the finish step until the
// output is free.
module page_allocator_best_worst_fit_core
   import pga_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data
);

   state_type state_ff, state_in;

   logic [NUM_PAGES-1:0] used_ff, used_in;
   logic                 fit_mode_ff;

   logic [1:0]           op_ff, op_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [NEED_BITS-1:0] need_ff, need_in;

   logic [CNT_BITS-1:0]  scan_ff, scan_in;
   logic                 dv_ff, dv_in;
   logic [PAGE_BITS-1:0] dp_ff, dp_in;

   logic                 present_ff, present_in;
   logic [CNT_BITS-1:0]  kill_cnt_ff, kill_cnt_in;
   logic [CNT_BITS-1:0]  frag_cnt_ff, frag_cnt_in;
   logic                 prev_used_ff, prev_used_in;
   logic [CNT_BITS-1:0]  run_len_ff, run_len_in;
   logic [PAGE_BITS-1:0] run_start_ff, run_start_in;
   logic                 best_found_ff, best_found_in;
   logic [CNT_BITS-1:0]  best_len_ff, best_len_in;
   logic [PAGE_BITS-1:0] best_start_ff, best_start_in;

   logic [PAGE_BITS-1:0] fill_page_ff, fill_page_in;
   logic [CNT_BITS-1:0]  fill_left_ff, fill_left_in;

   rsp_item_type         res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_item_ff, rsp_item_in;

   logic                 rd_en;
   logic [PAGE_BITS-1:0] rd_addr;
   logic [ID_BITS-1:0]   rd_data;
   logic                 wr_en;

   logic                 cur_used;
   logic                 cur_hit;
   logic                 cur_last;
   logic                 cand_valid;
   logic [CNT_BITS-1:0]  cand_len;
   logic [PAGE_BITS-1:0] cand_start;
   logic                 cand_better;
   logic [SUM_BITS-1:0]  size_sum;

   // owner table; reads only happen during the scan and writes only during
   // the fill, so accesses to one entry never overlap
   pga_ram #(
      .WIDTH(ID_BITS),
      .DEPTH(NUM_PAGES)
   ) u_owner_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(fill_page_ff),
      .wr_data(id_ff),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign size_sum = SUM_BITS'(req_item.size_kb) + SUM_BITS'(PAGE_KB - 1);

   // data stage of the scan: page dp_ff with its owner from the ram
   assign cur_used = used_ff[dp_ff];
   assign cur_hit  = dv_ff && cur_used && (rd_data == id_ff);
   assign cur_last = (dp_ff == PAGE_BITS'(NUM_PAGES - 1));

   always_comb begin
      cand_valid = 1'b0;
      cand_len   = run_len_ff;
      cand_start = run_start_ff;
      if (dv_ff) begin
         if (cur_used) begin
            // a free run just ended before this page
            cand_valid = (run_len_ff != '0);
         end else if (cur_last) begin
            cand_valid = 1'b1;
            cand_len   = run_len_ff + 1'b1;
            cand_start = (run_len_ff == '0) ? dp_ff : run_start_ff;
         end
      end
      if (!best_found_ff) begin
         cand_better = 1'b1;
      end else if (fit_mode_ff) begin
         cand_better = (cand_len > best_len_ff);
      end else begin
         cand_better = (cand_len < best_len_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      need_in       = need_ff;
      scan_in       = scan_ff;
      dv_in         = 1'b0;
      dp_in         = dp_ff;
      present_in    = present_ff;
      kill_cnt_in   = kill_cnt_ff;
      frag_cnt_in   = frag_cnt_ff;
      prev_used_in  = prev_used_ff;
      run_len_in    = run_len_ff;
      run_start_in  = run_start_ff;
      best_found_in = best_found_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      fill_page_in  = fill_page_ff;
      fill_left_in  = fill_left_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_item_in   = rsp_item_ff;
      rd_en         = 1'b0;
      rd_addr       = scan_ff[PAGE_BITS-1:0];
      wr_en         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_item.op;
               id_in         = req_item.program_id[ID_BITS-1:0];
               need_in       = NEED_BITS'(size_sum / PAGE_KB);
               scan_in       = '0;
               present_in    = 1'b0;
               kill_cnt_in   = '0;
               frag_cnt_in   = '0;
               prev_used_in  = 1'b0;
               run_len_in    = '0;
               run_start_in  = '0;
               best_found_in = 1'b0;
               best_len_in   = '0;
               best_start_in = '0;
               res_in        = '0;
               if (req_item.op == OP_ADD || req_item.op == OP_KILL ||
                   req_item.op == OP_FRAG) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         S_SCAN: begin
            if (scan_ff != CNT_BITS'(NUM_PAGES)) begin
               rd_en   = 1'b1;
               dv_in   = 1'b1;
               dp_in   = scan_ff[PAGE_BITS-1:0];
               scan_in = scan_ff + 1'b1;
            end
            if (dv_ff) begin
               if (cur_hit) begin
                  present_in = 1'b1;
                  if (op_ff == OP_KILL) begin
                     used_in[dp_ff] = 1'b0;
                     kill_cnt_in    = kill_cnt_ff + 1'b1;
                  end
               end
               // one used run per rising edge of the used bit
               if (cur_used && !prev_used_ff) begin
                  frag_cnt_in = frag_cnt_ff + 1'b1;
               end
               prev_used_in = cur_used;
               if (cur_used) begin
                  run_len_in = '0;
               end else begin
                  if (run_len_ff == '0) begin
                     run_start_in = dp_ff;
                  end
                  run_len_in = run_len_ff + 1'b1;
               end
               if (cand_valid && NEED_BITS'(cand_len) >= need_ff && cand_better) begin
                  best_found_in = 1'b1;
                  best_len_in   = cand_len;
                  best_start_in = cand_start;
               end
               if (cur_last) begin
                  state_in = S_DECIDE;
               end
            end
         end

         S_DECIDE: begin
            res_in   = '0;
            state_in = S_FINISH;
            case (op_ff)
               OP_ADD: begin
                  if (present_ff) begin
                     res_in.status = ST_RUNNING;
                  end else if (need_ff == '0) begin
                     res_in.status = ST_OK;
                  end else if (need_ff > NEED_BITS'(NUM_PAGES) || !best_found_ff) begin
                     res_in.status = ST_NOSPACE;
                  end else begin
                     res_in.status     = ST_OK;
                     res_in.pages      = PAGES_W'(need_ff);
                     res_in.start_page = START_W'(best_start_ff);
                     fill_page_in      = best_start_ff;
                     fill_left_in      = CNT_BITS'(need_ff);
                     state_in          = S_FILL;
                  end
               end
               OP_KILL: begin
                  res_in.pages = PAGES_W'(kill_cnt_ff);
               end
               OP_FRAG: begin
                  res_in.fragments = FRAGS_W'(frag_cnt_ff);
               end
               default: begin
                  res_in = '0;
               end
            endcase
         end

         S_FILL: begin
            wr_en                 = 1'b1;
            used_in[fill_page_ff] = 1'b1;
            fill_page_in          = fill_page_ff + 1'b1;
            fill_left_in          = fill_left_ff - 1'b1;
            if (fill_left_ff == CNT_BITS'(1)) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         fit_mode_ff  <= 1'b0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            fit_mode_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      need_ff       <= need_in;
      scan_ff       <= scan_in;
      dp_ff         <= dp_in;
      present_ff    <= present_in;
      kill_cnt_ff   <= kill_cnt_in;
      frag_cnt_ff   <= frag_cnt_in;
      prev_used_ff  <= prev_used_in;
      run_len_ff    <= run_len_in;
      run_start_ff  <= run_start_in;
      best_found_ff <= best_found_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      fill_page_ff  <= fill_page_in;
      fill_left_ff  <= fill_left_in;
      res_ff        <= res_in;
      rsp_item_ff   <= rsp_item_in;
   end

   // the fill only ever claims pages that the scan saw free
   a_fill_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FILL |-> !used_ff[fill_page_ff])
      else $error("fill overwrites a used page");

   // a chosen run never reaches past the last page
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FILL |->
         (CNT_BITS + 1)'(fill_page_ff) + (CNT_BITS + 1)'(fill_left_ff) <=
         (CNT_BITS + 1)'(NUM_PAGES))
      else $error("fill runs past the last page");

   // a finished scan never counts more used runs than used pages; a kill
   // frees pages during its scan, so it is left out
   a_frag_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DECIDE && op_ff != OP_KILL |->
         frag_cnt_ff <= CNT_BITS'($countones(used_ff)))
      else $error("fragment count exceeds used pages");

   // the data stage is only live while scanning
   a_scan_stage: assert property (@(posedge clock) disable iff (reset)
      dv_ff |-> state_ff == S_SCAN)
      else $error("scan data outside scan");

endmodule

// ----- tb/page_allocator_best_worst_fit_core_tb.sv -----
// page_allocator_best_worst_fit_core_tb: self-checking bench for the page allocator core.
// Drives add, kill and fragmentation requests in best and worst fit modes. It mirrors
// the page owner table to predict each response. Depends on pga_pkg and the core.
module page_allocator_best_worst_fit_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pga_pkg::*;

   localparam int CLK_PERIOD  = 12;
   localparam int RESET_CYCLES = 10;
   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 200;
   localparam int PRINT_LIMIT = 40;
   localparam int ID_POOL     = 12;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_data = 1'b0;

   // mirror of the allocator state
   bit                 pg_used [NUM_PAGES];
   logic [ID_BITS-1:0] pg_owner [NUM_PAGES];
   bit                 fit_worst;

   rsp_item_type pending_results [$];
   int           bad_fields = 0;
   int           rsp_seen = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;

   page_allocator_best_worst_fit_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic report_field(input string field, input int got, input int want);
      if (bad_fields < PRINT_LIMIT) begin
         $display("rsp %0d: %s is %0d, predicted %0d", rsp_seen, field, got, want);
      end
      bad_fields++;
   endtask

   function automatic int pages_in_use();
      int n;
      n = 0;
      for (int i = 0; i < NUM_PAGES; i++) begin
         if (pg_used[i]) n++;
      end
      return n;
   endfunction

   // computes the response of one request and updates the mirrored table
   function automatic rsp_item_type predict_allocator(input req_item_type r);
      rsp_item_type res;
      logic [ID_BITS-1:0] id;
      bit present, found, better;
      int need, i, s, len, best_len, best_start;
      res = '0;
      id = r.program_id[ID_BITS-1:0];
      case (r.op)
         OP_ADD: begin
            present = 1'b0;
            for (i = 0; i < NUM_PAGES; i++) begin
               if (pg_used[i] && pg_owner[i] == id) present = 1'b1;
            end
            if (present) begin
               res.status = ST_RUNNING;
            end else begin
               need = (int'(r.size_kb) + PAGE_KB - 1) / PAGE_KB;
               if (need > 0) begin
                  found = 1'b0;
                  best_len = 0;
                  best_start = 0;
                  i = 0;
                  // walk maximal free runs, first run wins on ties
                  while (i < NUM_PAGES) begin
                     if (pg_used[i]) begin
                        i++;
                     end else begin
                        s = i;
                        while (i < NUM_PAGES && !pg_used[i]) i++;
                        len = i - s;
                        if (len >= need) begin
                           if (!found) better = 1'b1;
                           else if (fit_worst) better = len > best_len;
                           else better = len < best_len;
                           if (better) begin
                              found = 1'b1;
                              best_len = len;
                              best_start = s;
                           end
                        end
                     end
                  end
                  if (need <= NUM_PAGES && found) begin
                     for (i = 0; i < need; i++) begin
                        pg_used[best_start + i] = 1'b1;
                        pg_owner[best_start + i] = id;
                     end
                     res.pages = PAGES_W'(need);
                     res.start_page = START_W'(best_start);
                  end else begin
                     res.status = ST_NOSPACE;
                  end
               end
            end
         end
         OP_KILL: begin
            need = 0;
            for (i = 0; i < NUM_PAGES; i++) begin
               if (pg_used[i] && pg_owner[i] == id) begin
                  pg_used[i] = 1'b0;
                  need++;
               end
            end
            res.pages = PAGES_W'(need);
         end
         OP_FRAG: begin
            need = 0;
            for (i = 0; i < NUM_PAGES; i++) begin
               if (pg_used[i] && (i + 1 == NUM_PAGES || !pg_used[i + 1])) need++;
            end
            res.fragments = FRAGS_W'(need);
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // sends one item after optional random idle cycles; valid is left high so back to back items need no gap
   task automatic send_req(input logic [1:0] op, input int id, input int size);
      req_item_type r;
      r.op = op;
      r.program_id = 8'(id);
      r.size_kb = SIZE_BITS'(size);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_allocator(r));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_fit_mode(input bit mode);
      csr_valid <= 1'b1;
      csr_data <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      fit_worst = mode;
   endtask

   // response checker and receiver back-pressure
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            if (bad_fields < PRINT_LIMIT) $display("rsp %0d arrived with none pending", rsp_seen);
            bad_fields++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_item.status !== want.status)
               report_field("status", rsp_item.status, want.status);
            if (rsp_item.pages !== want.pages)
               report_field("pages", rsp_item.pages, want.pages);
            if (rsp_item.start_page !== want.start_page)
               report_field("start_page", rsp_item.start_page, want.start_page);
            if (rsp_item.fragments !== want.fragments)
               report_field("fragments", rsp_item.fragments, want.fragments);
         end
         rsp_seen++;
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // watchdog on cycles with no transfer on any port
   always @(posedge clock) begin
      int quiet;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic test_best_fit_directed();
      wait_drained();
      write_fit_mode(1'b0);
      send_req(OP_FRAG, 0, 0);
      send_req(OP_ADD, 0, 0);        // zero size needs no pages
      send_req(OP_ADD, 1, 1);
      send_req(OP_ADD, 1, 4);        // already running
      send_req(OP_ADD, 255, 1023);   // far beyond memory
      send_req(OP_ADD, 2, 129);      // one page more than memory
      send_req(OP_ADD, 2, 8);
      send_req(OP_ADD, 3, 12);
      send_req(OP_ADD, 4, 4);
      send_req(OP_ADD, 5, 16);
      send_req(OP_KILL, 2, 0);
      send_req(OP_KILL, 4, 0);
      send_req(OP_ADD, 6, 3);        // smallest hole
      send_req(OP_ADD, 7, 5);
      send_req(OP_FRAG, 0, 0);
      send_req(2'd3, 255, 1023);     // unused op code
      send_req(OP_KILL, 9, 0);       // kill of absent id
   endtask

   task automatic test_worst_fit_directed();
      wait_drained();
      write_fit_mode(1'b1);
      send_req(OP_KILL, 6, 0);
      send_req(OP_KILL, 7, 0);
      send_req(OP_ADD, 8, 4);        // largest hole
      send_req(OP_FRAG, 0, 0);
      send_req(OP_KILL, 1, 0);
      send_req(OP_KILL, 3, 0);
      send_req(OP_KILL, 5, 0);
      send_req(OP_KILL, 8, 0);
      send_req(OP_ADD, 13, 128);     // whole memory
      send_req(OP_FRAG, 0, 0);
      send_req(OP_ADD, 12, 1);       // no space left
      send_req(OP_KILL, 13, 0);
   endtask

   task automatic send_random_req();
      int pick, add_pct, kill_pct, id, size;
      pick = $urandom_range(99);
      if (pick < 4) begin
         // noise over every field value, op code 3 included
         send_req(2'($urandom), $urandom_range(255), $urandom_range(1023));
      end else begin
         if (pages_in_use() > 24) begin
            add_pct = 30;
            kill_pct = 55;
         end else begin
            add_pct = 55;
            kill_pct = 30;
         end
         id = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(ID_POOL - 1);
         pick = $urandom_range(99);
         if (pick < add_pct) begin
            pick = $urandom_range(99);
            if (pick < 70) size = $urandom_range(24, 1);
            else if (pick < 85) size = $urandom_range(128, 25);
            else if (pick < 95) size = $urandom_range(1023, 129);
            else size = ($urandom_range(1) == 0) ? 0 : 4 * $urandom_range(32, 1);
            send_req(OP_ADD, id, size);
         end else if (pick < add_pct + kill_pct) begin
            send_req(OP_KILL, id, $urandom_range(1023));
         end else begin
            send_req(OP_FRAG, id, $urandom_range(1023));
         end
      end
   endtask

   task automatic test_random_traffic(input int count, input int tx_idle, input int rx_idle,
                                      input bit mode);
      wait_drained();
      write_fit_mode(mode);
      send_idle_pct = tx_idle;
      recv_idle_pct = rx_idle;
      for (int n = 0; n < count; n++) begin
         // on every 150th request the sender holds off until every response is back
         if (n % 150 == 149) wait_drained();
         send_random_req();
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_PAGES; i++) begin
         pg_used[i] = 1'b0;
         pg_owner[i] = '0;
      end
      fit_worst = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 11;
      recv_idle_pct = 63;
      test_best_fit_directed();
      test_worst_fit_directed();
      test_random_traffic(300, 11, 63, 1'b0);
      test_random_traffic(300, 11, 63, 1'b1);
      test_random_traffic(300, 63, 11, 1'b1);
      test_random_traffic(300, 63, 11, 1'b0);
      test_random_traffic(325, 0, 0, 1'b0);
      test_random_traffic(325, 0, 0, 1'b1);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (bad_fields == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
